FILE: sv/ebc_pkg.sv
// Shared types, pipeline constants and the saturation helper of the
// elastic ball collision block. Depends on nothing.
`default_nettype none

package ebc_pkg;

   // Back pipeline layout: registered stages 1 .. BK_LAST.
   localparam int SQ_STEPS = 21;                  // root bits of the distance
   localparam int VQ_BITS  = 19;                  // doubled velocity quotient
   localparam int PQ_BITS  = 15;                  // doubled push quotient
   localparam int PMUL_T   = SQ_STEPS + 1;        // transition forming push numerators
   localparam int BK_LAST  = PMUL_T + PQ_BITS + 1;
   localparam int Q_DEPTH  = 4;

   typedef struct packed {
      logic signed [15:0] a_x;
      logic signed [15:0] a_y;
      logic signed [15:0] a_vx;
      logic signed [15:0] a_vy;
      logic [11:0]        a_radius;
      logic signed [15:0] b_x;
      logic signed [15:0] b_y;
      logic signed [15:0] b_vx;
      logic signed [15:0] b_vy;
      logic [11:0]        b_radius;
      logic               b_visible;
      logic               b_enable;
   } req_type;

   typedef struct packed {
      logic signed [15:0] new_a_x;
      logic signed [15:0] new_a_y;
      logic signed [15:0] new_a_vx;
      logic signed [15:0] new_a_vy;
      logic signed [15:0] new_b_x;
      logic signed [15:0] new_b_y;
      logic signed [15:0] new_b_vx;
      logic signed [15:0] new_b_vy;
      logic               resolved;
   } rsp_type;

   // Classified pair as it waits between the front and the back.
   typedef struct packed {
      req_type            pay;
      logic               hit;
      logic signed [13:0] dx;
      logic signed [13:0] dy;
      logic signed [31:0] dot;
      logic [25:0]        d2;
      logic [12:0]        sum_r;
   } ent_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      req_type            pay;
      logic               hit;
      logic signed [13:0] dx;
      logic signed [13:0] dy;
      logic [12:0]        sum_r;
      logic [25:0]        d2;
      logic [45:0]        vnum_x;
      logic [45:0]        vnum_y;
      logic               vneg_x;
      logic               vneg_y;
      logic [18:0]        vq_x;
      logic [18:0]        vq_y;
      logic [41:0]        sq_rem;
      logic [41:0]        sq_res;
      logic [35:0]        pnum_x;
      logic [35:0]        pnum_y;
      logic [20:0]        pden;
      logic [14:0]        pq_x;
      logic [14:0]        pq_y;
   } bk_type;

   function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
      logic signed [15:0] r;
      if (v > 24'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -24'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/ebc_front.sv
// Front end: differences, products and the collision test for each pair.
// Depends on ebc_pkg.
`default_nettype none

module ebc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ebc_pkg::req_type req_data,
   input  wire ebc_pkg::q_status_type q_stat,
   output logic                  q_push,
   output ebc_pkg::ent_type      q_data
);
   import ebc_pkg::*;

   logic en;
   logic f1_v_ff, f2_v_ff;
   req_type f1_pay_ff, f2_pay_ff;
   logic signed [16:0] f1_dx_ff, f1_dy_ff, f1_dvx_ff, f1_dvy_ff;
   logic [12:0] f1_s_ff, f2_s_ff;
   logic signed [16:0] f2_dx_ff, f2_dy_ff;
   logic signed [33:0] f2_dx2_ff, f2_dy2_ff, f2_pvx_ff, f2_pvy_ff;
   logic [25:0] f2_s2_ff;
   logic [34:0] d2_c;
   logic signed [34:0] dot_c;
   logic active;

   assign en        = !(f2_v_ff && q_stat.full);
   assign req_ready = en;
   assign q_push    = f2_v_ff && !q_stat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else if (en) begin
         f1_v_ff <= req_valid;
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_pay_ff <= req_data;
         f1_dx_ff  <= 17'($signed(req_data.a_x)) - 17'($signed(req_data.b_x));
         f1_dy_ff  <= 17'($signed(req_data.a_y)) - 17'($signed(req_data.b_y));
         f1_dvx_ff <= 17'($signed(req_data.a_vx)) - 17'($signed(req_data.b_vx));
         f1_dvy_ff <= 17'($signed(req_data.a_vy)) - 17'($signed(req_data.b_vy));
         f1_s_ff   <= {1'b0, req_data.a_radius} + {1'b0, req_data.b_radius};
         f2_pay_ff <= f1_pay_ff;
         f2_dx_ff  <= f1_dx_ff;
         f2_dy_ff  <= f1_dy_ff;
         f2_s_ff   <= f1_s_ff;
         f2_dx2_ff <= f1_dx_ff * f1_dx_ff;
         f2_dy2_ff <= f1_dy_ff * f1_dy_ff;
         f2_pvx_ff <= f1_dvx_ff * f1_dx_ff;
         f2_pvy_ff <= f1_dvy_ff * f1_dy_ff;
         f2_s2_ff  <= f1_s_ff * f1_s_ff;
      end
   end

   always_comb begin
      d2_c   = 35'($unsigned(f2_dx2_ff)) + 35'($unsigned(f2_dy2_ff));
      dot_c  = 35'(f2_pvx_ff) + 35'(f2_pvy_ff);
      active = f2_pay_ff.b_visible && f2_pay_ff.b_enable;
      q_data.pay   = f2_pay_ff;
      q_data.hit   = active && (d2_c != 35'd0) && (d2_c < {9'd0, f2_s2_ff})
                     && (dot_c[34] || (dot_c == 35'sd0));
      q_data.dx    = f2_dx_ff[13:0];
      q_data.dy    = f2_dy_ff[13:0];
      q_data.dot   = dot_c[31:0];
      q_data.d2    = d2_c[25:0];
      q_data.sum_r = f2_s_ff;
   end

endmodule

`default_nettype wire

FILE: sv/ebc_queue.sv
// Short queue of classified pairs between front and back end.
// Depends on ebc_pkg.
`default_nettype none

module ebc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ebc_pkg::ent_type wr_data,
   input  wire logic             pop,
   output ebc_pkg::ent_type      rd_data,
   output ebc_pkg::q_status_type stat
);
   import ebc_pkg::*;

   localparam int PW = $clog2(Q_DEPTH);

   ent_type slot_ff [Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   cnt_ff;

   assign stat.full  = (cnt_ff == (PW+1)'(Q_DEPTH));
   assign stat.empty = (cnt_ff == '0);
   assign rd_data    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ebc_back.sv
// Back end: pipelined square root and dividers, then the response and the
// output register. Depends on ebc_pkg.
`default_nettype none

module ebc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ebc_pkg::ent_type ent,
   input  wire ebc_pkg::q_status_type q_stat,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ebc_pkg::rsp_type      rsp_data
);
   import ebc_pkg::*;

   logic en;
   logic [BK_LAST:1] v_ff;
   bk_type bk_ff [1:BK_LAST];
   bk_type bk_in [1:BK_LAST];
   logic rsp_valid_ff;
   rsp_type rsp_ff, fin;

   logic signed [45:0] prod_x, prod_y, mag_x, mag_y;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign q_pop     = en && !q_stat.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [42:0] trial;
      logic [41:0] bitv;
      logic [45:0] dshift;
      logic [35:0] pshift;
      logic signed [22:0] ov;
      logic [12:0] adx, ady;
      bk_type b;

      // Entry: velocity numerators (doubled, for rounding) and root seed.
      prod_x = 46'($signed(ent.dot)) * 46'($signed(ent.dx));
      prod_y = 46'($signed(ent.dot)) * 46'($signed(ent.dy));
      mag_x  = prod_x[45] ? -prod_x : prod_x;
      mag_y  = prod_y[45] ? -prod_y : prod_y;
      b = '0;
      b.pay    = ent.pay;
      b.hit    = ent.hit;
      b.dx     = ent.dx;
      b.dy     = ent.dy;
      b.sum_r  = ent.sum_r;
      b.d2     = ent.d2;
      b.vnum_x = {mag_x[44:0], 1'b0};
      b.vnum_y = {mag_y[44:0], 1'b0};
      b.vneg_x = prod_x[45];
      b.vneg_y = prod_y[45];
      b.sq_rem = {ent.d2, 16'd0};
      b.sq_res = '0;
      bk_in[1] = b;

      for (int t = 1; t < BK_LAST; t++) begin
         b = bk_ff[t];
         if (t <= SQ_STEPS) begin
            bitv  = 42'd1 << (2 * (SQ_STEPS - t));
            trial = {1'b0, b.sq_res} + {1'b0, bitv};
            if ({1'b0, b.sq_rem} >= trial) begin
               b.sq_rem = b.sq_rem - trial[41:0];
               b.sq_res = (b.sq_res >> 1) + bitv;
            end else begin
               b.sq_res = b.sq_res >> 1;
            end
         end
         if (t <= VQ_BITS) begin
            dshift = {20'd0, b.d2} << (VQ_BITS - t);
            if (b.vnum_x >= dshift) begin
               b.vnum_x = b.vnum_x - dshift;
               b.vq_x[VQ_BITS - t] = 1'b1;
            end
            if (b.vnum_y >= dshift) begin
               b.vnum_y = b.vnum_y - dshift;
               b.vq_y[VQ_BITS - t] = 1'b1;
            end
         end
         if (t == PMUL_T) begin
            ov  = 23'({b.sum_r, 8'd0}) - 23'(b.sq_res[20:0]);
            adx = b.dx[13] ? 13'(-b.dx) : b.dx[12:0];
            ady = b.dy[13] ? 13'(-b.dy) : b.dy[12:0];
            b.pnum_x = 36'(ov[21:0] * adx);
            b.pnum_y = 36'(ov[21:0] * ady);
            b.pden   = b.sq_res[20:0];
            b.pq_x   = '0;
            b.pq_y   = '0;
         end
         if (t > PMUL_T) begin
            pshift = {15'd0, b.pden} << (BK_LAST - 1 - t);
            if (b.pnum_x >= pshift) begin
               b.pnum_x = b.pnum_x - pshift;
               b.pq_x[BK_LAST - 1 - t] = 1'b1;
            end
            if (b.pnum_y >= pshift) begin
               b.pnum_y = b.pnum_y - pshift;
               b.pq_y[BK_LAST - 1 - t] = 1'b1;
            end
         end
         bk_in[t+1] = b;
      end
   end

   // Final rounding, update and saturation of a hit; other pairs pass through unchanged.
   always_comb begin
      logic [19:0] rvx, rvy;
      logic [14:0] rpx, rpy;
      logic signed [19:0] kx, ky;
      logic signed [15:0] px, py;
      bk_type b;
      b   = bk_ff[BK_LAST];
      rvx = (20'(b.vq_x) + 20'd1) >> 1;
      rvy = (20'(b.vq_y) + 20'd1) >> 1;
      rpx = 15'((16'(b.pq_x) + 16'd1) >> 1);
      rpy = 15'((16'(b.pq_y) + 16'd1) >> 1);
      kx  = b.vneg_x ? -$signed(rvx) : $signed(rvx);
      ky  = b.vneg_y ? -$signed(rvy) : $signed(rvy);
      px  = b.dx[13] ? -$signed({1'b0, rpx}) : $signed({1'b0, rpx});
      py  = b.dy[13] ? -$signed({1'b0, rpy}) : $signed({1'b0, rpy});
      if (b.hit) begin
         fin.new_a_x  = sat16(24'($signed(b.pay.a_x)) + 24'(px));
         fin.new_a_y  = sat16(24'($signed(b.pay.a_y)) + 24'(py));
         fin.new_a_vx = sat16(24'($signed(b.pay.a_vx)) - 24'(kx));
         fin.new_a_vy = sat16(24'($signed(b.pay.a_vy)) - 24'(ky));
         fin.new_b_x  = sat16(24'($signed(b.pay.b_x)) - 24'(px));
         fin.new_b_y  = sat16(24'($signed(b.pay.b_y)) - 24'(py));
         fin.new_b_vx = sat16(24'($signed(b.pay.b_vx)) + 24'(kx));
         fin.new_b_vy = sat16(24'($signed(b.pay.b_vy)) + 24'(ky));
         fin.resolved = 1'b1;
      end else begin
         fin.new_a_x  = b.pay.a_x;
         fin.new_a_y  = b.pay.a_y;
         fin.new_a_vx = b.pay.a_vx;
         fin.new_a_vy = b.pay.a_vy;
         fin.new_b_x  = b.pay.b_x;
         fin.new_b_y  = b.pay.b_y;
         fin.new_b_vx = b.pay.b_vx;
         fin.new_b_vy = b.pay.b_vy;
         fin.resolved = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[BK_LAST-1:1], !q_stat.empty};
         rsp_valid_ff <= v_ff[BK_LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int t = 1; t <= BK_LAST; t++) begin
            bk_ff[t] <= bk_in[t];
         end
         rsp_ff <= fin;
      end
   end

endmodule

`default_nettype wire

FILE: sv/elastic_ball_collision_top.sv
// Equal-mass elastic collision response for one pair of discs per transaction.
// A transaction passes the front registers, queue, back stages and output register.
// Throughput: one transaction per cycle while responses are taken, set by the fully
// pipelined square root (21 stages) and the one-bit-per-stage back-end dividers.
// Reset is synchronous and active high; it empties the pipeline and the queue.
`default_nettype none

module elastic_ball_collision_top (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire ebc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output ebc_pkg::rsp_type      rsp_data
);
   import ebc_pkg::*;

   // The front end works out the separation, the squared distance and the
   // normal speed, and decides whether the pair is resolved at all.
   ent_type      q_wr, q_rd;
   q_status_type q_stat;
   logic         q_push, q_pop;

   ebc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_data    (q_wr)
   );

   // The queue lets the front end keep taking transactions while the back
   // end is held by a stalled response.
   ebc_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr),
      .pop     (q_pop),
      .rd_data (q_rd),
      .stat    (q_stat)
   );

   // The back end computes the impulse and the separation push and holds the
   // finished transaction in its output register until it is taken.
   ebc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ent       (q_rd),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: dv/elastic_ball_collision_top_tb.sv
// Self-checking testbench for the equal-mass disc collision block.
// Depends on ebc_pkg and elastic_ball_collision_top; drives random and directed pairs.
`default_nettype none

module elastic_ball_collision_top_tb;
   import ebc_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // A directed row: the pair and, where it is obvious, the typed-in answer.
   typedef struct {
      req_type pair;
      bit      has_answer;
      rsp_type answer;
   } directed_row_type;

   rsp_type          expected_collisions[$];
   directed_row_type directed_rows[$];
   int               mismatch_count;
   bit               stimulus_done;
   bit               hold_off_active;

   elastic_ball_collision_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Signed division rounded to nearest, ties away from zero; the divisor is positive.
   function automatic longint round_div(input longint num, input longint den);
      longint mag;
      longint quo;
      mag = (num < 0) ? -num : num;
      quo = (mag + den / 2) / den;
      return (num < 0) ? -quo : quo;
   endfunction

   function automatic longint floor_sqrt(input longint n);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = 64'd3037000499;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= n) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // Works out the collision response for one pair of discs.
   function automatic rsp_type resolve_pair(input req_type p);
      rsp_type r;
      longint  dx, dy, d2, sr, dot, kx, ky, root_d, over, px, py;
      bit      hit;
      dx  = longint'(p.a_x) - longint'(p.b_x);
      dy  = longint'(p.a_y) - longint'(p.b_y);
      d2  = dx * dx + dy * dy;
      sr  = longint'(p.a_radius) + longint'(p.b_radius);
      dot = (longint'(p.a_vx) - longint'(p.b_vx)) * dx
          + (longint'(p.a_vy) - longint'(p.b_vy)) * dy;
      hit = p.b_visible && p.b_enable && d2 != 0 && d2 < sr * sr && dot <= 0;
      r.new_a_x  = p.a_x;
      r.new_a_y  = p.a_y;
      r.new_a_vx = p.a_vx;
      r.new_a_vy = p.a_vy;
      r.new_b_x  = p.b_x;
      r.new_b_y  = p.b_y;
      r.new_b_vx = p.b_vx;
      r.new_b_vy = p.b_vy;
      r.resolved = hit;
      if (hit) begin
         kx     = round_div(dot * dx, d2);
         ky     = round_div(dot * dy, d2);
         root_d = floor_sqrt(d2 * 65536);
         over   = sr * 256 - root_d;
         px     = round_div(over * dx, 2 * root_d);
         py     = round_div(over * dy, 2 * root_d);
         r.new_a_x  = clamp16(longint'(p.a_x) + px);
         r.new_a_y  = clamp16(longint'(p.a_y) + py);
         r.new_a_vx = clamp16(longint'(p.a_vx) - kx);
         r.new_a_vy = clamp16(longint'(p.a_vy) - ky);
         r.new_b_x  = clamp16(longint'(p.b_x) - px);
         r.new_b_y  = clamp16(longint'(p.b_y) - py);
         r.new_b_vx = clamp16(longint'(p.b_vx) + kx);
         r.new_b_vy = clamp16(longint'(p.b_vy) + ky);
      end
      return r;
   endfunction

   function automatic req_type make_pair(input int ax, input int ay, input int avx,
                                         input int avy, input int ar, input int bx,
                                         input int by, input int bvx, input int bvy,
                                         input int br, input bit vis, input bit en);
      req_type p;
      p.a_x = 16'(ax); p.a_y = 16'(ay); p.a_vx = 16'(avx); p.a_vy = 16'(avy);
      p.a_radius = 12'(ar);
      p.b_x = 16'(bx); p.b_y = 16'(by); p.b_vx = 16'(bvx); p.b_vy = 16'(bvy);
      p.b_radius = 12'(br);
      p.b_visible = vis; p.b_enable = en;
      return p;
   endfunction

   // Pass-through answer, typed in wherever the pair cannot resolve.
   function automatic rsp_type unchanged(input req_type p);
      rsp_type r;
      r = '{p.a_x, p.a_y, p.a_vx, p.a_vy, p.b_x, p.b_y, p.b_vx, p.b_vy, 1'b0};
      return r;
   endfunction

   function automatic void add_row(input req_type p, input bit typed_in);
      directed_row_type row;
      row.pair       = p;
      row.has_answer = typed_in;
      row.answer     = typed_in ? unchanged(p) : '0;
      directed_rows.push_back(row);
   endfunction

   // Mostly overlapping pairs with random content; the rest is noise.
   function automatic req_type random_pair();
      req_type      p;
      logic [191:0] raw;
      int           sel;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      p   = raw[$bits(req_type)-1:0];
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         p.a_radius  = 12'($urandom_range(1, 4095));
         p.b_radius  = 12'($urandom_range(1, 4095));
         p.b_x       = p.a_x - $signed(16'($urandom_range(0, 2 * p.a_radius) - p.a_radius));
         p.b_y       = p.a_y - $signed(16'($urandom_range(0, 2 * p.b_radius) - p.b_radius));
         p.b_visible = ($urandom_range(0, 9) != 0);
         p.b_enable  = ($urandom_range(0, 9) != 0);
         if (sel < 2) begin
            // Small sizes and small x speeds keep the rounding near its ties.
            p.a_radius = 12'($urandom_range(1, 40));
            p.b_radius = 12'($urandom_range(1, 40));
            p.b_x  = p.a_x + $signed(16'($urandom_range(0, 40) - 20));
            p.b_y  = p.a_y + $signed(16'($urandom_range(0, 40) - 20));
            p.a_vx = 16'($urandom_range(0, 64) - 32);
            p.b_vx = 16'($urandom_range(0, 64) - 32);
         end
      end
      return p;
   endfunction

   // Drives one transaction at a falling edge and holds it until it is accepted.
   // Idle cycles before it are drawn first; valid drops only while idling.
   task automatic offer_pair(input req_type p, input bit typed_in, input rsp_type answer);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      expected_collisions.push_back(typed_in ? answer : resolve_pair(p));
      do @(posedge clock); while (!req_ready);
   endtask

   // Sender.
   initial begin
      rsp_type blank;
      int      i;
      blank         = '0;
      req_valid     = 1'b0;
      req_data      = '0;
      stimulus_done = 1'b0;
      mismatch_count = 0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(make_pair(0, 0, 0, 0, 16, 0, 0, 0, 0, 16, 1, 1), 1);              // coincident
      add_row(make_pair(0, 0, -32, 0, 16, 16, 0, 0, 0, 16, 1, 1), 1);           // separating
      add_row(make_pair(0, 0, -32, 0, 16, 16, 0, 0, 0, 16, 0, 1), 1);           // hidden B
      add_row(make_pair(0, 0, -32, 0, 16, 16, 0, 0, 0, 16, 1, 0), 1);           // disabled B
      add_row(make_pair(0, 0, 0, 0, 1, 1000, 1000, 5, 5, 1, 1, 1), 1);          // far apart
      add_row(make_pair(32767, 32767, 32767, 32767, 4095,
                        -32768, -32768, -32768, -32768, 4095, 1, 1), 1);       // extremes
      add_row(make_pair(-32768, -32768, -32768, -32768, 0,
                        32767, 32767, 32767, 32767, 0, 1, 1), 1);
      add_row(make_pair(0, 0, 32, 0, 16, 16, 0, -32, 0, 16, 1, 1), 0);          // head-on
      add_row(make_pair(0, 0, 0, 40, 16, 16, 0, 0, -40, 16, 1, 1), 0);          // zero normal speed
      add_row(make_pair(0, 0, 0, 0, 16, 0, 16, 0, 0, 16, 1, 1), 0);             // resting overlap
      add_row(make_pair(10, 7, -300, 200, 100, 20, -5, 400, -100, 90, 1, 1), 0);
      add_row(make_pair(32767, 32767, -32768, -32768, 4095,
                        32760, 32760, 32767, 32767, 4095, 1, 1), 0);           // saturating
      add_row(make_pair(-32768, -32768, 32767, 0, 4095,
                        -32760, -32768, -32768, 0, 4095, 1, 1), 0);
      add_row(make_pair(0, 0, 0, 0, 4095, 1, 0, 0, 0, 4095, 1, 1), 0);          // deepest overlap
      add_row(make_pair(0, 0, -1, -1, 1, 1, 1, 1, 1, 1, 1, 1), 0);

      foreach (directed_rows[k])
         offer_pair(directed_rows[k].pair, directed_rows[k].has_answer,
                    directed_rows[k].answer);
      for (i = 0; i < 500; i++) offer_pair(random_pair(), 1'b0, blank);
      @(negedge clock);
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // One long hold-off of the receiver, counted in cycles in its own process.
   initial begin
      hold_off_active = 1'b0;
      @(negedge reset);
      repeat (200) @(negedge clock);
      hold_off_active = 1'b1;
      repeat (600) @(negedge clock);
      hold_off_active = 1'b0;
   end

   // Receiver: draws the idle cycles before taking each response transaction.
   initial begin
      int idle;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
         @(negedge clock);
         if (idle != 0 || hold_off_active) begin
            rsp_ready <= 1'b0;
            repeat (idle) @(negedge clock);
            while (hold_off_active) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Each accepted response transaction is compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_collisions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response transaction: %p", rsp_data);
         end else begin
            want = expected_collisions.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: expected %p, actual %p", want, rsp_data);
            end
         end
      end
   end

   // Drains the pipeline, allowing for its latency, then reports.
   initial begin
      int waited;
      waited = 0;
      wait (stimulus_done);
      while (expected_collisions.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_collisions.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
